// ===== rtl/lmc_pkg.sv =====
// ----------------------------------------------------------------------------
// lmc_pkg: shared types and constants of the decimal accumulator machine
// Request and result layouts, memory port bundle, opcode names and the
// decimal instruction splitter.
// ----------------------------------------------------------------------------
package lmc_pkg;

    localparam int MEM_WORDS = 100;
    localparam int ADDR_W    = $clog2(MEM_WORDS);
    localparam int WORD_W    = 16;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MEM_WORDS - 1);
    localparam logic [ADDR_W-1:0] MEM_TOP   = ADDR_W'(MEM_WORDS);

    // request opcodes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_RESET = 2'd1;
    localparam logic [1:0] OP_EXEC  = 2'd2;

    // instruction codes (hundreds digit of a word)
    localparam logic [3:0] IC_HALT  = 4'd0;
    localparam logic [3:0] IC_ADD   = 4'd1;
    localparam logic [3:0] IC_SUB   = 4'd2;
    localparam logic [3:0] IC_STORE = 4'd3;
    localparam logic [3:0] IC_LOAD  = 4'd5;
    localparam logic [3:0] IC_BR    = 4'd6;
    localparam logic [3:0] IC_BRZ   = 4'd7;
    localparam logic [3:0] IC_BRP   = 4'd8;
    localparam logic [3:0] IC_IO    = 4'd9;

    // operand codes of the I/O instruction
    localparam logic [ADDR_W-1:0] IO_IN  = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] IO_OUT = ADDR_W'(2);

    // reciprocal of 100 for words below 1000: q = (w * 41) >> 12
    localparam logic [15:0] DEC_MUL = 16'd41;
    localparam logic [9:0]  DEC_BASE = 10'd100;
    localparam logic signed [WORD_W-1:0] HALT_LO = -16'sd99;
    localparam logic signed [WORD_W-1:0] HALT_HI = 16'sd99;
    localparam logic signed [WORD_W-1:0] INSN_LO = 16'sd100;
    localparam logic signed [WORD_W-1:0] INSN_HI = 16'sd999;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [ADDR_W-1:0] address;
        logic [WORD_W-1:0] write_data;
        logic [WORD_W-1:0] in_value;
    } t_item;

    typedef struct packed {
        logic [WORD_W-1:0] instr_word;
        logic [WORD_W-1:0] acc;
        logic [ADDR_W-1:0] pc;
        logic              halted;
        logic              out_valid;
        logic              in_taken;
    } t_result;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [WORD_W-1:0] wr_data;
    } t_memreq;

    typedef struct packed {
        logic              known;   // halt or a word in 100..999
        logic [3:0]        code;
        logic [ADDR_W-1:0] arg;
    } t_dec;

    // Split a word into hundreds digit and remainder. Only words from -99
    // to 999 decode to anything; the rest leave the machine untouched.
    function automatic t_dec dec_word(input logic signed [WORD_W-1:0] w);
        t_dec       d;
        logic       halt;
        logic [15:0] prod;
        logic [9:0]  rem;
        prod  = {6'b0, w[9:0]} * DEC_MUL;
        rem   = w[9:0] - ({6'b0, prod[15:12]} * DEC_BASE);
        halt  = (w >= HALT_LO) && (w <= HALT_HI);
        d.known = halt || ((w >= INSN_LO) && (w <= INSN_HI));
        d.code  = halt ? IC_HALT : prod[15:12];
        d.arg   = rem[ADDR_W-1:0];
        return d;
    endfunction

endpackage

// ===== rtl/lmc_mem.sv =====
// ----------------------------------------------------------------------------
// lmc_mem: main memory of the machine
// One write and one read port, registered read data. Per-word valid flags
// make unwritten words read as zero right after reset.
// ----------------------------------------------------------------------------
module lmc_mem
    import lmc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_memreq           i_mreq,
    output logic [WORD_W-1:0] o_rd_data
);

    logic [WORD_W-1:0] r_mem [MEM_WORDS];
    logic [MEM_WORDS-1:0] r_vld;
    logic [WORD_W-1:0] r_q;
    logic              r_q_vld;

    always_ff @(posedge i_clk) begin
        if (i_mreq.wr_en) begin
            r_mem[i_mreq.wr_addr] <= i_mreq.wr_data;
        end
        if (i_mreq.rd_en) begin
            r_q <= r_mem[i_mreq.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_q_vld <= 1'b0;
        end else begin
            if (i_mreq.wr_en) begin
                r_vld[i_mreq.wr_addr] <= 1'b1;
            end
            if (i_mreq.rd_en) begin
                r_q_vld <= r_vld[i_mreq.rd_addr];
            end
        end
    end

    assign o_rd_data = r_q_vld ? r_q : '0;

endmodule

// ===== rtl/lmc_seq.sv =====
// ----------------------------------------------------------------------------
// lmc_seq: request sequencer and architectural registers
// Walks each execute request through fetch, decode/operand access and
// execute; write and reset requests finish in the fetch step.
// ----------------------------------------------------------------------------
module lmc_seq
    import lmc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  t_item             i_item,
    output logic              o_in_ready,
    input  logic              i_out_free,
    output logic              o_res_valid,
    output t_result           o_res,
    output t_memreq           o_mreq,
    input  logic [WORD_W-1:0] i_rd_data
);

    typedef enum logic [1:0] {S_IDLE, S_FETCH, S_DECODE, S_EXEC} t_state;

    t_state            r_state, n_state;
    t_item             r_item, n_item;
    logic [ADDR_W-1:0] r_pc, n_pc;
    logic [WORD_W-1:0] r_acc, n_acc;
    logic              r_halt, n_halt;
    logic [WORD_W-1:0] r_word, n_word;
    t_dec              r_dec, n_dec;
    t_dec              dec;
    logic [ADDR_W-1:0] pc_inc;
    logic              finish;
    logic              outv;
    logic              took;

    assign pc_inc = (r_pc == LAST_ADDR) ? '0 : r_pc + 1'b1;
    assign dec    = dec_word(i_rd_data);

    always_comb begin
        n_state = r_state;
        n_item  = r_item;
        n_pc    = r_pc;
        n_acc   = r_acc;
        n_halt  = r_halt;
        n_word  = r_word;
        n_dec   = r_dec;
        o_mreq  = '0;
        finish  = 1'b0;
        outv    = 1'b0;
        took    = 1'b0;
        case (r_state)
            S_IDLE: begin
            end
            S_FETCH: begin
                if (r_item.opcode == OP_EXEC) begin
                    o_mreq.rd_en   = 1'b1;
                    o_mreq.rd_addr = r_pc;
                    n_state        = S_DECODE;
                end else if (i_out_free) begin
                    finish = 1'b1;
                    case (r_item.opcode)
                        OP_WRITE: begin
                            if (r_item.address < MEM_TOP) begin
                                o_mreq.wr_en   = 1'b1;
                                o_mreq.wr_addr = r_item.address;
                                o_mreq.wr_data = r_item.write_data;
                            end
                        end
                        OP_RESET: begin
                            n_pc   = '0;
                            n_acc  = '0;
                            n_halt = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DECODE: begin
                n_word         = i_rd_data;
                n_dec          = dec;
                o_mreq.rd_en   = 1'b1;
                o_mreq.rd_addr = (dec.arg < MEM_TOP) ? dec.arg : '0;
                // store writes back here, ahead of the next fetch
                if (dec.known && dec.code == IC_STORE) begin
                    o_mreq.wr_en   = 1'b1;
                    o_mreq.wr_addr = dec.arg;
                    o_mreq.wr_data = r_acc;
                end
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_out_free) begin
                    finish = 1'b1;
                    if (r_dec.known) begin
                        case (r_dec.code)
                            IC_HALT: begin
                                n_pc   = '0;
                                n_acc  = '0;
                                n_halt = 1'b1;
                            end
                            IC_ADD: begin
                                n_acc = r_acc + i_rd_data;
                                n_pc  = pc_inc;
                            end
                            IC_SUB: begin
                                n_acc = r_acc - i_rd_data;
                                n_pc  = pc_inc;
                            end
                            IC_STORE: begin
                                n_pc = pc_inc;
                            end
                            IC_LOAD: begin
                                n_acc = i_rd_data;
                                n_pc  = pc_inc;
                            end
                            IC_BR: begin
                                n_pc = r_dec.arg;
                            end
                            IC_BRZ: begin
                                n_pc = (r_acc == '0) ? r_dec.arg : pc_inc;
                            end
                            IC_BRP: begin
                                n_pc = !r_acc[WORD_W-1] ? r_dec.arg : pc_inc;
                            end
                            IC_IO: begin
                                if (r_dec.arg == IO_IN) begin
                                    n_acc = r_item.in_value;
                                    took  = 1'b1;
                                    n_pc  = pc_inc;
                                end else if (r_dec.arg == IO_OUT) begin
                                    outv = 1'b1;
                                    n_pc = pc_inc;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        o_in_ready = (r_state == S_IDLE) || finish;
        if (finish) begin
            n_state = S_IDLE;
        end
        if (o_in_ready && i_in_valid) begin
            n_state = S_FETCH;
            n_item  = i_item;
        end

        o_res_valid          = finish;
        o_res.instr_word     = (r_state == S_EXEC) ? r_word : '0;
        o_res.acc            = n_acc;
        o_res.pc             = n_pc;
        o_res.halted         = n_halt;
        o_res.out_valid      = outv;
        o_res.in_taken       = took;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
            r_acc   <= '0;
            r_halt  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_acc   <= n_acc;
            r_halt  <= n_halt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_word <= n_word;
        r_dec  <= n_dec;
    end

endmodule

// ===== rtl/accumulator_decimal_cpu_step.sv =====
// ----------------------------------------------------------------------------
// accumulator_decimal_cpu_step: decimal accumulator machine, one step per request
// Top level: request port, sequencer, main memory and the result register.
// ----------------------------------------------------------------------------
// Usage:
//   Requests come in on i_valid/o_stall and are taken at a rising edge with
//   i_valid high and o_stall low. A request writes one memory word, clears
//   PC, AC and the halted flag, or runs the instruction at PC. Every request
//   gives exactly one result on o_valid/i_stall, taken at an edge with
//   o_valid high and i_stall low.
//   Steps: a write or reset request finishes in its fetch step; an execute
//   request goes through a fetch read, an operand read or store write, and
//   the update. Throughput: one write or reset request per cycle while the
//   result register is free; after an execute request the next request is
//   taken only as it finishes. The single read port of main memory serves
//   the fetch and then the operand.
//   Reset: synchronous, active low. PC, AC and halted clear, and every memory
//   word reads as zero until written; no clearing pass is needed.
//   Stall: the result register holds while i_stall is high. The next request
//   is still taken and worked up to its last step, then waits for the
//   register to drain. o_stall is high while a request is in work (the fetch
//   and decode cycles of an execute request) and while it waits there.
// ----------------------------------------------------------------------------
module accumulator_decimal_cpu_step
    import lmc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_opcode,
    input  logic [ADDR_W-1:0] i_address,
    input  logic [WORD_W-1:0] i_write_data,
    input  logic [WORD_W-1:0] i_in_value,
    // result channel
    output logic              o_valid,
    input  logic              i_stall,
    output logic [WORD_W-1:0] o_instr_word,
    output logic [WORD_W-1:0] o_acc,
    output logic [ADDR_W-1:0] o_pc,
    output logic              o_halted,
    output logic              o_out_valid,
    output logic              o_in_taken
);

    t_item             item;
    t_memreq           mreq;
    t_result           res;
    t_result           r_res;
    logic              r_valid;
    logic              in_ready;
    logic              res_valid;
    logic              out_free;
    logic [WORD_W-1:0] rd_data;

    // pack the request fields
    assign item.opcode     = i_opcode;
    assign item.address    = i_address;
    assign item.write_data = i_write_data;
    assign item.in_value   = i_in_value;

    // the result register can take a new result when empty or draining
    assign out_free = !r_valid || !i_stall;
    assign o_stall  = !in_ready;

    lmc_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_item      (item),
        .o_in_ready  (in_ready),
        .i_out_free  (out_free),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_mreq      (mreq),
        .i_rd_data   (rd_data)
    );

    lmc_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mreq    (mreq),
        .o_rd_data (rd_data)
    );

    // result register: load on a finished step, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (res_valid) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_res <= res;
        end
    end

    assign o_valid      = r_valid;
    assign o_instr_word = r_res.instr_word;
    assign o_acc        = r_res.acc;
    assign o_pc         = r_res.pc;
    assign o_halted     = r_res.halted;
    assign o_out_valid  = r_res.out_valid;
    assign o_in_taken   = r_res.in_taken;

endmodule

// ===== rtl/lmc_chk.sv =====
// ----------------------------------------------------------------------------
// lmc_chk: port checker of the decimal accumulator machine
// Watches the result channel for held results, PC range and consistent status flags.
// ----------------------------------------------------------------------------
module lmc_chk
    import lmc_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_stall,
    input logic [WORD_W-1:0] o_instr_word,
    input logic [WORD_W-1:0] o_acc,
    input logic [ADDR_W-1:0] o_pc,
    input logic              o_out_valid,
    input logic              o_in_taken
);

    localparam logic [WORD_W-1:0] WORD_IN  = 16'd901;
    localparam logic [WORD_W-1:0] WORD_OUT = 16'd902;

    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_acc) && $stable(o_pc))
        else $error("stalled result changed");

    // keep PC inside memory
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_pc < MEM_TOP)
        else $error("pc beyond memory");

    // flag output only for the output instruction
    a_out_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_valid |-> o_instr_word == WORD_OUT && !o_in_taken)
        else $error("output flag without output instruction");

    // flag input only for the input instruction
    a_in_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_in_taken |-> o_instr_word == WORD_IN)
        else $error("input flag without input instruction");

endmodule

bind accumulator_decimal_cpu_step lmc_chk u_lmc_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_instr_word (o_instr_word),
    .o_acc        (o_acc),
    .o_pc         (o_pc),
    .o_out_valid  (o_out_valid),
    .o_in_taken   (o_in_taken)
);
